// ===== rtl/core/sorted_set_merge_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted set merge engine assertion macros
// Concurrent assertion helpers shared by the engine modules. Defining
// NO_ASSERTIONS compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_MERGE_ENGINE_ASSERT_SVH
`define SORTED_SET_MERGE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold on every clock edge outside reset.
`define SSME_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition in one cycle that implies a consequence in the next one.
`define SSME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSME_ASSERT(label, clk, rst, prop, msg)
`define SSME_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ssme_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine package
// Shared constants, command and mode codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ssme_pkg;

   // Sizes fixed by the item format.
   localparam int DATA_W             = 32;
   localparam int CMD_W              = 2;
   localparam int MODE_W             = 2;
   localparam int DEFAULT_LIST_DEPTH = 32;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RUN      = 2'd3;

   // Set operation codes held in the mode register. The last code selects
   // no operation, and a run under it reports an empty set.
   localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNION     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic append_a;
      logic append_b;
      logic start;
      logic step;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ssme_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine controller
// Accepts requests, decodes commands and sequences the merge steps of a run
// against the availability of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_set_merge_engine_assert.svh"

module ssme_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [ssme_pkg::CMD_W-1:0]  req_tuser,
   input  wire ssme_pkg::dp_status_type     stat,
   output ssme_pkg::dp_cmd_type             cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  ssme_pkg::CMD_CLEAR:    cmd.clear    = 1'b1;
                  ssme_pkg::CMD_APPEND_A: cmd.append_a = 1'b1;
                  ssme_pkg::CMD_APPEND_B: cmd.append_b = 1'b1;
                  ssme_pkg::CMD_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // A step or the closing item goes ahead only when the result
            // register can take a value this cycle.
            if (stat.out_free) begin
               if (stat.active) begin
                  cmd.step = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SSME_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "controller issued two commands at once")
   `SSME_ASSERT(a_busy_no_ready, clock, reset, !((state_ff == ST_RUN) && req_tready), "request accepted during a run")
   `SSME_ASSERT_NEXT(a_finish_idle, clock, reset, cmd.finish, (state_ff == ST_IDLE), "run did not end after its closing item")

endmodule

`default_nettype wire

// ===== rtl/core/ssme_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine datapath
// Holds the two lists, their counts, the overflow flag and the mode register,
// walks both lists one merge step at a time and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_set_merge_engine_assert.svh"

module ssme_dp #(
   parameter int LIST_DEPTH = ssme_pkg::DEFAULT_LIST_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ssme_pkg::dp_cmd_type          cmd,
   output ssme_pkg::dp_status_type            stat,
   input  wire logic [ssme_pkg::DATA_W-1:0]   elem_value,
   input  wire logic                          csr_wr_en,
   input  wire logic [ssme_pkg::MODE_W-1:0]   csr_wr_data,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ssme_pkg::DATA_W-1:0]        rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int DW = ssme_pkg::DATA_W;
   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   // List storage, written at the fill count, read at the walk index.
   logic [DW-1:0] list_a_mem [LIST_DEPTH];
   logic [DW-1:0] list_b_mem [LIST_DEPTH];

   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic          ovf_ff, ovf_in;
   logic [ssme_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [CW-1:0] idx_a_ff, idx_a_in;
   logic [CW-1:0] idx_b_ff, idx_b_in;
   logic [DW-1:0] pend_val_ff, pend_val_in;
   logic          pend_vld_ff, pend_vld_in;
   logic          out_vld_ff, out_vld_in;
   logic [DW-1:0] out_val_ff, out_val_in;
   logic          out_flag_ff, out_flag_in;
   logic          out_last_ff, out_last_in;
   logic          out_ovf_ff, out_ovf_in;
   logic [DW-1:0] a_rd_ff, b_rd_ff;

   logic          a_ok, b_ok, a_room, b_room;
   logic [DW-1:0] a_val, b_val;
   logic          act, emit, inc_a, inc_b, keep;
   logic [DW-1:0] emit_val;

   // Heads of both lists and their bounds.
   always_comb begin
      a_ok   = (idx_a_ff < count_a_ff);
      b_ok   = (idx_b_ff < count_b_ff);
      a_room = (count_a_ff < CW'(LIST_DEPTH));
      b_room = (count_b_ff < CW'(LIST_DEPTH));
      a_val  = a_rd_ff;
      b_val  = b_rd_ff;
   end

   // One merge step of the selected set operation.
   always_comb begin
      act      = 1'b0;
      emit     = 1'b0;
      inc_a    = 1'b0;
      inc_b    = 1'b0;
      emit_val = a_val;
      case (mode_ff)
         ssme_pkg::MODE_INTERSECT: begin
            act = a_ok && b_ok;
            if (a_val == b_val) begin
               emit  = 1'b1;
               inc_a = 1'b1;
               inc_b = 1'b1;
            end else if (a_val < b_val) begin
               inc_a = 1'b1;
            end else begin
               inc_b = 1'b1;
            end
         end
         ssme_pkg::MODE_UNION: begin
            act  = a_ok || b_ok;
            emit = 1'b1;
            if (a_ok && b_ok) begin
               if (a_val < b_val) begin
                  inc_a = 1'b1;
               end else if (b_val < a_val) begin
                  emit_val = b_val;
                  inc_b    = 1'b1;
               end else begin
                  inc_a = 1'b1;
                  inc_b = 1'b1;
               end
            end else if (a_ok) begin
               inc_a = 1'b1;
            end else begin
               emit_val = b_val;
               inc_b    = 1'b1;
            end
         end
         ssme_pkg::MODE_DIFF: begin
            act = a_ok;
            if (b_ok && (a_val == b_val)) begin
               inc_a = 1'b1;
               inc_b = 1'b1;
            end else if (!b_ok || (a_val < b_val)) begin
               emit  = 1'b1;
               inc_a = 1'b1;
            end else begin
               inc_b = 1'b1;
            end
         end
         default: act = 1'b0;
      endcase
      // The pending value is always the one emitted last; union drops repeats.
      keep = emit && !((mode_ff == ssme_pkg::MODE_UNION) && pend_vld_ff
                       && (pend_val_ff == emit_val));
   end

   // Next-state logic for counts, walk indexes, pending value and output.
   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      ovf_in      = ovf_ff;
      mode_in     = csr_wr_en ? csr_wr_data : mode_ff;
      idx_a_in    = idx_a_ff;
      idx_b_in    = idx_b_ff;
      pend_val_in = pend_val_ff;
      pend_vld_in = pend_vld_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_val_in  = out_val_ff;
      out_flag_in = out_flag_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;

      if (cmd.clear) begin
         count_a_in  = '0;
         count_b_in  = '0;
         ovf_in      = 1'b0;
         pend_vld_in = 1'b0;
      end
      if (cmd.append_a) begin
         if (a_room) begin
            count_a_in = count_a_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.append_b) begin
         if (b_room) begin
            count_b_in = count_b_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.start) begin
         idx_a_in    = '0;
         idx_b_in    = '0;
         pend_vld_in = 1'b0;
      end

      // A kept value replaces the pending one, which moves to the output.
      if (cmd.step) begin
         if (inc_a) idx_a_in = idx_a_ff + CW'(1);
         if (inc_b) idx_b_in = idx_b_ff + CW'(1);
         if (keep) begin
            pend_val_in = emit_val;
            pend_vld_in = 1'b1;
            if (pend_vld_ff) begin
               out_vld_in  = 1'b1;
               out_val_in  = pend_val_ff;
               out_flag_in = 1'b1;
               out_last_in = 1'b0;
               out_ovf_in  = ovf_ff;
            end
         end
      end

      // The closing item carries the pending value, or reports an empty set.
      if (cmd.finish) begin
         out_vld_in  = 1'b1;
         out_val_in  = pend_vld_ff ? pend_val_ff : '0;
         out_flag_in = pend_vld_ff;
         out_last_in = 1'b1;
         out_ovf_in  = ovf_ff;
         pend_vld_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         ovf_ff      <= 1'b0;
         mode_ff     <= ssme_pkg::MODE_INTERSECT;
         idx_a_ff    <= '0;
         idx_b_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         ovf_ff      <= ovf_in;
         mode_ff     <= mode_in;
         idx_a_ff    <= idx_a_in;
         idx_b_ff    <= idx_b_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_val_ff <= pend_val_in;
      out_val_ff  <= out_val_in;
      out_flag_ff <= out_flag_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // List writes at the current fill count.
   always_ff @(posedge clock) begin
      if (cmd.append_a && a_room) begin
         list_a_mem[count_a_ff[IW-1:0]] <= elem_value;
      end
      if (cmd.append_b && b_room) begin
         list_b_mem[count_b_ff[IW-1:0]] <= elem_value;
      end
   end

   // List reads at the index the walk moves to, so each head is ready in the
   // cycle after the step. No append can land in the cycle a run starts.
   always_ff @(posedge clock) begin
      a_rd_ff <= list_a_mem[idx_a_in[IW-1:0]];
      b_rd_ff <= list_b_mem[idx_b_in[IW-1:0]];
   end

   // Status and result port.
   always_comb begin
      stat.active   = act;
      stat.out_free = !out_vld_ff || rsp_tready;
      rsp_tvalid    = out_vld_ff;
      rsp_tdata     = out_val_ff;
      rsp_tuser     = {out_ovf_ff, out_flag_ff};
      rsp_tlast     = out_last_ff;
   end

   `SSME_ASSERT_NEXT(a_finish_out, clock, reset, cmd.finish, rsp_tvalid && rsp_tlast, "closing item missing after a run")
   `SSME_ASSERT(a_empty_zero, clock, reset, !(rsp_tvalid && !out_flag_ff) || (rsp_tlast && (rsp_tdata == '0)), "empty-set item is malformed")
   `SSME_ASSERT(a_idx_bound, clock, reset, !cmd.step || (idx_a_ff <= count_a_ff && idx_b_ff <= count_b_ff), "walk index ran past a list")

endmodule

`default_nettype wire

// ===== rtl/core/sorted_set_merge_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine
// Loads two ascending lists and merges them into their intersection, union or
// difference, one result value per item on the result stream.
// ----------------------------------------------------------------------------
// Clear and append requests complete in the cycle they are accepted, so they
// stream at one per cycle. A run request first enters the merge, then takes
// its merge steps (at most count_a + count_b steps, each step reading one head
// of each list), then sends the closing item. The merge waits whenever the
// single result register is full and not being taken. No request is accepted
// while a run is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_merge_engine #(
   parameter int LIST_DEPTH = ssme_pkg::DEFAULT_LIST_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ssme_pkg::DATA_W-1:0]   req_tdata,   // [31:0] element_value
   input  wire logic [ssme_pkg::CMD_W-1:0]    req_tuser,   // [1:0] cmd
   // Result channel.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ssme_pkg::DATA_W-1:0]        rsp_tdata,   // [31:0] result_value
   output logic [1:0]                         rsp_tuser,   // [0] result_valid, [1] overflow_seen
   output logic                               rsp_tlast,   // result_last
   // Mode register write port.
   input  wire logic                          csr_wr_en,
   input  wire logic [ssme_pkg::MODE_W-1:0]   csr_wr_data  // [1:0] set_mode
);

   ssme_pkg::dp_cmd_type    dp_cmd;
   ssme_pkg::dp_status_type dp_stat;

   // Request decode and run sequencing.
   ssme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   // Lists, merge step and result register.
   ssme_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .elem_value  (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== bench/ssme_set_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine result checker
// Watches the request, result and mode register ports of the engine. It keeps
// its own copy of both lists and of the mode, works out the result items of
// every run request, and compares each result taken from the engine with the
// oldest pending item, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ssme_set_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [ssme_pkg::DATA_W-1:0] req_tdata,   // [31:0] element_value
   input  wire logic [ssme_pkg::CMD_W-1:0]  req_tuser,   // [1:0] cmd
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [ssme_pkg::DATA_W-1:0] rsp_tdata,   // [31:0] result_value
   input  wire logic [1:0]                  rsp_tuser,   // [0] result_valid, [1] overflow_seen
   input  wire logic                        rsp_tlast,   // result_last
   input  wire logic                        csr_wr_en,
   input  wire logic [ssme_pkg::MODE_W-1:0] csr_wr_data, // [1:0] set_mode
   output int                               mismatch_count,
   output int                               results_due
);

   localparam int DEPTH = ssme_pkg::DEFAULT_LIST_DEPTH;

   // One item of the result stream.
   typedef struct packed {
      logic [ssme_pkg::DATA_W-1:0] value;
      logic                        valid;
      logic                        last;
      logic                        overflow;
   } set_item_type;

   // Shadow copy of the engine state.
   logic [ssme_pkg::DATA_W-1:0] a_values [DEPTH];
   logic [ssme_pkg::DATA_W-1:0] b_values [DEPTH];
   int unsigned                 a_len;
   int unsigned                 b_len;
   logic                        append_dropped;
   logic [ssme_pkg::MODE_W-1:0] mode_reg;

   // Items still owed by the engine, oldest first.
   set_item_type                set_items_due [$];

   // Values of the run being merged, and the union duplicate filter.
   logic [ssme_pkg::DATA_W-1:0] run_values [$];
   logic [ssme_pkg::DATA_W-1:0] union_prev;
   logic                        union_prev_ok;

   initial begin
      mismatch_count = 0;
      results_due    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: result mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Union drops a value equal to the one it emitted just before.
   function automatic void emit_union_value(input logic [ssme_pkg::DATA_W-1:0] v);
      if (union_prev_ok && union_prev == v) begin
         return;
      end
      union_prev    = v;
      union_prev_ok = 1'b1;
      run_values.insert(run_values.size(), v);
   endfunction

   // Walk both lists once in the current mode and queue the items of the run.
   function automatic void merge_lists();
      int unsigned i;
      int unsigned j;
      i = 0;
      j = 0;
      run_values.delete();
      union_prev_ok = 1'b0;
      case (mode_reg)
         ssme_pkg::MODE_INTERSECT: begin
            while (i < a_len && j < b_len) begin
               if (a_values[i] == b_values[j]) begin
                  run_values.insert(run_values.size(), a_values[i]);
                  i++;
                  j++;
               end else if (a_values[i] < b_values[j]) begin
                  i++;
               end else begin
                  j++;
               end
            end
         end
         ssme_pkg::MODE_UNION: begin
            while (i < a_len && j < b_len) begin
               if (a_values[i] < b_values[j]) begin
                  emit_union_value(a_values[i]);
                  i++;
               end else if (b_values[j] < a_values[i]) begin
                  emit_union_value(b_values[j]);
                  j++;
               end else begin
                  emit_union_value(a_values[i]);
                  i++;
                  j++;
               end
            end
            for (; i < a_len; i++) begin
               emit_union_value(a_values[i]);
            end
            for (; j < b_len; j++) begin
               emit_union_value(b_values[j]);
            end
         end
         ssme_pkg::MODE_DIFF: begin
            // A values left over once B is exhausted are all emitted.
            while (i < a_len) begin
               if (j < b_len && a_values[i] == b_values[j]) begin
                  i++;
                  j++;
               end else if (j >= b_len || a_values[i] < b_values[j]) begin
                  run_values.insert(run_values.size(), a_values[i]);
                  i++;
               end else begin
                  j++;
               end
            end
         end
         default: begin
            // A mode without meaning yields the empty result.
         end
      endcase
      if (run_values.size() == 0) begin
         set_items_due.insert(set_items_due.size(),
                              '{value: '0, valid: 1'b0, last: 1'b1,
                                overflow: append_dropped});
      end else begin
         foreach (run_values[k]) begin
            set_items_due.insert(set_items_due.size(),
                                 '{value: run_values[k], valid: 1'b1,
                                   last: (k == run_values.size() - 1),
                                   overflow: append_dropped});
         end
      end
   endfunction

   // Update the shadow state for one accepted request.
   function automatic void apply_request(input logic [ssme_pkg::CMD_W-1:0]  cmd,
                                         input logic [ssme_pkg::DATA_W-1:0] value);
      case (cmd)
         ssme_pkg::CMD_CLEAR: begin
            a_len          = 0;
            b_len          = 0;
            append_dropped = 1'b0;
         end
         ssme_pkg::CMD_APPEND_A: begin
            if (a_len < DEPTH) begin
               a_values[a_len] = value;
               a_len++;
            end else begin
               append_dropped = 1'b1;
            end
         end
         ssme_pkg::CMD_APPEND_B: begin
            if (b_len < DEPTH) begin
               b_values[b_len] = value;
               b_len++;
            end else begin
               append_dropped = 1'b1;
            end
         end
         default: begin
            merge_lists();
         end
      endcase
   endfunction

   // Sample all three ports at each rising edge.
   always @(posedge clock) begin : watch_ports
      set_item_type seen;
      set_item_type want;
      if (reset) begin
         a_len          = 0;
         b_len          = 0;
         append_dropped = 1'b0;
         mode_reg       = ssme_pkg::MODE_INTERSECT;
         set_items_due.delete();
      end else begin
         if (csr_wr_en) begin
            mode_reg = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = '{value: rsp_tdata, valid: rsp_tuser[0], last: rsp_tlast,
                     overflow: rsp_tuser[1]};
            if (set_items_due.size() == 0) begin
               report_mismatch($sformatf("result %h arrived with nothing pending",
                                         rsp_tdata));
            end else begin
               want = set_items_due.pop_front();
               if (seen !== want) begin
                  report_mismatch($sformatf(
                     "got value %h valid %b last %b overflow %b, expected %h %b %b %b",
                     seen.value, seen.valid, seen.last, seen.overflow,
                     want.value, want.valid, want.last, want.overflow));
               end
            end
         end
      end
      results_due <= set_items_due.size();
   end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted set merge engine testbench
// Drives clear, append and run requests through the engine under each set
// mode, with random gaps on the request side and random stalls on the result
// side. A checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [ssme_pkg::DATA_W-1:0] req_tdata = '0;    // [31:0] element_value
   logic [ssme_pkg::CMD_W-1:0]  req_tuser = '0;    // [1:0] cmd
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [ssme_pkg::DATA_W-1:0] rsp_tdata;         // [31:0] result_value
   logic [1:0]                  rsp_tuser;         // [0] result_valid, [1] overflow_seen
   logic                        rsp_tlast;         // result_last
   logic                        csr_wr_en = 1'b0;
   logic [ssme_pkg::MODE_W-1:0] csr_wr_data = '0;  // [1:0] set_mode
   int                          mismatch_count;
   int                          results_due;
   logic                        idle_enable = 1'b1;

   sorted_set_merge_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ssme_set_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Clock with a period of four time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: ready stretches broken by random stall bursts.
   always begin
      rsp_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clock);
      if (idle_enable && $urandom_range(0, 1) == 1) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Present one request, with an occasional gap first, and hold it until taken.
   task automatic send_request(input logic [ssme_pkg::CMD_W-1:0]  cmd,
                               input logic [ssme_pkg::DATA_W-1:0] value);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop requesting and wait until every pending result has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic [ssme_pkg::MODE_W-1:0] mode);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Walk an ascending run of values and hand each one to A, B, both or
   // neither, so the lists overlap. A few out-of-order appends are mixed in.
   task automatic load_and_run(input int elements, input int span, input bit fresh);
      logic [ssme_pkg::DATA_W-1:0] v;
      int                          k;
      v = $urandom_range(0, 32'hC000_0000);
      if (fresh) begin
         send_request(ssme_pkg::CMD_CLEAR, $urandom());
      end
      for (k = 0; k < elements; k++) begin
         v = v + $urandom_range(0, span);
         if ($urandom_range(0, 15) == 0) begin
            send_request($urandom_range(0, 1) ? ssme_pkg::CMD_APPEND_A
                                              : ssme_pkg::CMD_APPEND_B, $urandom());
         end
         if ($urandom_range(0, 2) != 0) begin
            send_request(ssme_pkg::CMD_APPEND_A, v);
         end
         if ($urandom_range(0, 2) != 0) begin
            send_request(ssme_pkg::CMD_APPEND_B, v);
         end
      end
      send_request(ssme_pkg::CMD_RUN, $urandom());
   endtask

   task automatic random_phase(input logic [ssme_pkg::MODE_W-1:0] mode);
      write_mode(mode);
      repeat (2) begin
         load_and_run($urandom_range(0, 7), 1 << $urandom_range(0, 24),
                      $urandom_range(0, 3) != 0);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      logic [ssme_pkg::DATA_W-1:0] base;
      int                          k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Run on empty lists, then field extremes under every mode.
      send_request(ssme_pkg::CMD_RUN, 32'hFFFF_FFFF);
      send_request(ssme_pkg::CMD_APPEND_A, 32'h0000_0000);
      send_request(ssme_pkg::CMD_APPEND_A, 32'h0000_0005);
      send_request(ssme_pkg::CMD_APPEND_A, 32'hFFFF_FFFF);
      send_request(ssme_pkg::CMD_APPEND_B, 32'h0000_0000);
      send_request(ssme_pkg::CMD_APPEND_B, 32'h0000_0007);
      send_request(ssme_pkg::CMD_APPEND_B, 32'hFFFF_FFFF);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      write_mode(ssme_pkg::MODE_UNION);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      write_mode(ssme_pkg::MODE_DIFF);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      // B no longer ascending.
      send_request(ssme_pkg::CMD_APPEND_B, 32'h0000_0005);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      // Mode code without meaning.
      write_mode(ssme_pkg::MODE_NONE);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      // Difference with B empty, then intersection with no match.
      write_mode(ssme_pkg::MODE_DIFF);
      send_request(ssme_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      send_request(ssme_pkg::CMD_APPEND_A, 32'hAAAA_5555);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);
      send_request(ssme_pkg::CMD_APPEND_B, 32'h5555_AAAA);
      write_mode(ssme_pkg::MODE_INTERSECT);
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);

      // Both lists filled past their depth, disjoint, so union gives the
      // longest possible run with the overflow flag raised.
      write_mode(ssme_pkg::MODE_UNION);
      send_request(ssme_pkg::CMD_CLEAR, 32'h0000_0000);
      base = $urandom_range(0, 32'h8000_0000);
      for (k = 0; k < ssme_pkg::DEFAULT_LIST_DEPTH + 1; k++) begin
         send_request(ssme_pkg::CMD_APPEND_A, base + 32'(2 * k));
         send_request(ssme_pkg::CMD_APPEND_B, base + 32'(2 * k + 1));
      end
      send_request(ssme_pkg::CMD_RUN, 32'h0000_0000);

      // Random lists under each mode; the last phase runs without idling.
      random_phase(ssme_pkg::MODE_DIFF);
      random_phase(ssme_pkg::MODE_INTERSECT);
      random_phase(ssme_pkg::MODE_UNION);
      idle_enable = 1'b0;
      random_phase(ssme_pkg::MODE_DIFF);

      wait_idle();
      repeat (2 * ssme_pkg::DEFAULT_LIST_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
